// ===== rtl/bha_pkg.sv =====
`default_nettype none

package bha_pkg;

  localparam int MAX_HANDLES_DEF = 256;
  localparam int ITEM_BITS_DEF   = 32;

  localparam int HANDLE_W  = 8;
  localparam int VALUE_W   = 32;
  localparam int CAP_W     = 9;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  // Largest handle count that the 8-bit handle fields can name.
  localparam int HANDLE_SPACE = 256;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_GET   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_OK_ALLOC,
    RES_OK_FREE,
    RES_OK_GET,
    RES_FULL,
    RES_BAD
  } res_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_next;
    logic alloc_commit;
    logic free_commit;
    logic rd_issue;
    logic res_load;
    res_e res_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              in_use;
    logic              found;
    logic              last_word;
    logic              slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bha_req_if.sv =====
`default_nettype none

interface bha_req_if;
  import bha_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] handle;
  logic [VALUE_W-1:0]  item_value;

  modport source (output valid, output kind, output handle, output item_value, input ready);
  modport sink   (input valid, input kind, input handle, input item_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/bha_rsp_if.sv =====
`default_nettype none

interface bha_rsp_if;
  import bha_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic [VALUE_W-1:0]  item_out;

  modport source (output valid, output status, output handle_out, output item_out, input ready);
  modport sink   (input valid, input status, input handle_out, input item_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/bha_ram.sv =====
`default_nettype none

module bha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bha_ctrl.sv =====
`default_nettype none

module bha_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire bha_pkg::dp_status_t    status_i,
  output      bha_pkg::ctrl_cmd_t     cmd_o
);
  import bha_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, scan_next: 1'b0, alloc_commit: 1'b0, free_commit: 1'b0,
                   rd_issue: 1'b0, res_load: 1'b0, res_code: RES_BAD};
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status_i.kind)
          KIND_ALLOC: begin
            // The scan keeps walking words even while the result slot is busy;
            // only the commit waits for the slot.
            if (status_i.found) begin
              if (status_i.slot_free) begin
                cmd_o.alloc_commit = 1'b1;
                cmd_o.res_load     = 1'b1;
                cmd_o.res_code     = RES_OK_ALLOC;
                state_d            = S_IDLE;
              end
            end else if (status_i.last_word) begin
              if (status_i.slot_free) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_code = RES_FULL;
                state_d        = S_IDLE;
              end
            end else begin
              cmd_o.scan_next = 1'b1;
            end
          end
          KIND_FREE: begin
            if (status_i.slot_free) begin
              cmd_o.free_commit = status_i.in_use;
              cmd_o.res_load    = 1'b1;
              cmd_o.res_code    = status_i.in_use ? RES_OK_FREE : RES_BAD;
              state_d           = S_IDLE;
            end
          end
          KIND_GET: begin
            if (status_i.in_use) begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_READ;
            end else if (status_i.slot_free) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = RES_BAD;
              state_d        = S_IDLE;
            end
          end
          default: begin
            if (status_i.slot_free) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = RES_BAD;
              state_d        = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        if (status_i.slot_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = RES_OK_GET;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> $past(state_q) == S_EXEC || $past(state_q) == S_READ)
    else $error("read state entered without a get check");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_EXEC)
    else $error("accepted beat did not start execution");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> !cmd_o.rd_issue)
    else $error("get issued two reads");

endmodule

`default_nettype wire

// ===== rtl/bha_dp.sv =====
`default_nettype none

module bha_dp #(
  parameter int MAX_HANDLES = bha_pkg::MAX_HANDLES_DEF,
  parameter int ITEM_BITS   = bha_pkg::ITEM_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bha_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  wire logic [bha_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [bha_pkg::HANDLE_W-1:0]   handle_i,
  input  wire logic [bha_pkg::VALUE_W-1:0]    item_value_i,
  input  wire bha_pkg::ctrl_cmd_t             cmd_i,
  output      bha_pkg::dp_status_t            status_o,
  output      logic                           rsp_valid_o,
  input  wire logic                           rsp_ready_i,
  output      logic [bha_pkg::STATUS_W-1:0]   rsp_status_o,
  output      logic [bha_pkg::HANDLE_W-1:0]   rsp_handle_o,
  output      logic [bha_pkg::VALUE_W-1:0]    rsp_item_o
);
  import bha_pkg::*;

  localparam int USED     = (MAX_HANDLES < HANDLE_SPACE) ? MAX_HANDLES : HANDLE_SPACE;
  localparam int WORDS    = (USED + WORD_BITS - 1) / WORD_BITS;
  localparam int MAP_BITS = WORDS * WORD_BITS;
  localparam int MW       = $clog2(MAP_BITS);
  localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int AW       = $clog2(USED);
  localparam int WIDE_W   = (ITEM_BITS > VALUE_W) ? ITEM_BITS : VALUE_W;
  localparam logic [CAP_W-1:0] USED_CAP = CAP_W'(USED);

  logic [CAP_W-1:0]     cap_q;
  logic [KIND_W-1:0]    kind_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [ITEM_BITS-1:0] item_q;
  logic [WW-1:0]        word_q;
  logic [MAP_BITS-1:0]  free_q;

  logic                 rsp_valid_q;
  status_e              rsp_status_q;
  logic [HANDLE_W-1:0]  rsp_handle_q;
  logic [VALUE_W-1:0]   rsp_item_q;

  logic [CAP_W-1:0]     eff_cap;
  logic [CAP_W-1:0]     base;
  logic [CAP_W-1:0]     remain;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     bit_idx;
  logic [MW-1:0]        alloc_idx;
  logic [MW-1:0]        h_idx;
  logic                 in_use;
  logic                 slot_free;
  logic [ITEM_BITS-1:0] rd_data;
  logic [WIDE_W-1:0]    rd_wide;

  assign eff_cap = (cap_q > USED_CAP) ? USED_CAP : cap_q;

  // Handles of the current word that lie below the effective capacity.
  assign base     = CAP_W'({word_q, BIT_W'(0)});
  assign remain   = eff_cap - base;
  assign cur_word = free_q[word_q * WORD_BITS +: WORD_BITS];

  always_comb begin
    if (eff_cap <= base) begin
      avail = '0;
    end else if (remain >= CAP_W'(WORD_BITS)) begin
      avail = '1;
    end else begin
      avail = (WORD_BITS'(1) << remain[BIT_W-1:0]) - WORD_BITS'(1);
    end
  end

  assign masked = cur_word & avail;
  assign lowest = masked & (~masked + WORD_BITS'(1));

  always_comb begin
    bit_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        bit_idx = bit_idx | BIT_W'(j);
      end
    end
  end

  assign alloc_idx = MW'({word_q, bit_idx});
  assign h_idx     = handle_q[MW-1:0];
  assign in_use    = ({1'b0, handle_q} < eff_cap) && !free_q[h_idx];
  assign slot_free = !rsp_valid_q || rsp_ready_i;

  assign status_o.kind      = kind_q;
  assign status_o.in_use    = in_use;
  assign status_o.found     = |masked;
  assign status_o.last_word = ({1'b0, base} + (CAP_W + 1)'(WORD_BITS)) >= {1'b0, eff_cap};
  assign status_o.slot_free = slot_free;

  bha_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (USED)
  ) u_items (
    .clk_i   (clk_i),
    .we_i    (cmd_i.alloc_commit),
    .waddr_i (alloc_idx[AW-1:0]),
    .wdata_i (item_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (h_idx[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_wide = WIDE_W'(rd_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      free_q      <= '1;
      rsp_valid_q <= 1'b0;
      word_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        word_q <= '0;
      end else if (cmd_i.scan_next) begin
        word_q <= word_q + WW'(1);
      end
      if (cmd_i.alloc_commit) begin
        free_q[alloc_idx] <= 1'b0;
      end else if (cmd_i.free_commit) begin
        free_q[h_idx] <= 1'b1;
      end
      if (cmd_i.res_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      handle_q <= handle_i;
      item_q   <= ITEM_BITS'(item_value_i);
    end
    if (cmd_i.res_load) begin
      rsp_handle_q <= '0;
      rsp_item_q   <= '0;
      case (cmd_i.res_code)
        RES_OK_ALLOC: begin
          rsp_status_q <= ST_OK;
          rsp_handle_q <= HANDLE_W'(alloc_idx);
        end
        RES_OK_FREE: rsp_status_q <= ST_OK;
        RES_OK_GET: begin
          rsp_status_q <= ST_OK;
          rsp_item_q   <= rd_wide[VALUE_W-1:0];
        end
        RES_FULL: rsp_status_q <= ST_FULL;
        default:  rsp_status_q <= ST_BAD;
      endcase
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_status_q;
  assign rsp_handle_o = rsp_handle_q;
  assign rsp_item_o   = rsp_item_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> !rsp_valid_q || rsp_ready_i)
    else $error("result overwrote an untaken beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_commit |-> {1'b0, alloc_idx} < (MW + 1)'(eff_cap) && free_q[alloc_idx])
    else $error("alloc took a handle that was not free or not usable");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_commit |=> !free_q[$past(alloc_idx)])
    else $error("alloc did not clear the free bit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free_commit |=> free_q[$past(h_idx)])
    else $error("free did not set the free bit");

endmodule

`default_nettype wire

// ===== rtl/bitmap_handle_allocator.sv =====
`default_nettype none

// An alloc scans the bitmap one word per cycle until it finds a free handle below the
// capacity or reaches the last word; free, get of a bad handle and an unused kind finish
// in the check state; get of a live handle adds an item RAM read. One request at a time:
// the next is taken once the result is loaded, even before that result beat is taken.
// Reset (rst_ni, asynchronous, active low) marks every handle free and sets capacity to 256;
// the item RAM is not cleared, since every handle is written before it can be read.
module bitmap_handle_allocator #(
  parameter int MAX_HANDLES = bha_pkg::MAX_HANDLES_DEF,
  parameter int ITEM_BITS   = bha_pkg::ITEM_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [bha_pkg::CAP_W-1:0] cfg_wdata_i,
  bha_req_if.sink                        req_i,
  bha_rsp_if.source                      rsp_o
);
  import bha_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  bha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  bha_dp #(
    .MAX_HANDLES (MAX_HANDLES),
    .ITEM_BITS   (ITEM_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (req_i.kind),
    .handle_i     (req_i.handle),
    .item_value_i (req_i.item_value),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_handle_o (rsp_o.handle_out),
    .rsp_item_o   (rsp_o.item_out)
  );

endmodule

`default_nettype wire
